// ===== hdl/ptc_pkg.sv =====
package ptc_pkg;

  localparam int TEMP_W     = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;
  localparam int FAIL_W     = 3;
  localparam int ELAPSED_W  = 15;
  localparam int LIMIT_W    = 14;

  localparam logic signed [TEMP_W-1:0] FAIL_MARK = -8'sd90;
  localparam logic [FAIL_W-1:0]        FAIL_MAX  = 3'd7;
  localparam logic [ELAPSED_W-1:0]     ELAPSED_MAX = 15'd32767;
  localparam logic [5:0]               SECONDS_PER_MINUTE = 6'd60;

  localparam logic signed [TEMP_W-1:0] RST_LOW_ON    = 8'sd45;
  localparam logic signed [TEMP_W-1:0] RST_HIGH_OFF  = 8'sd55;
  localparam logic signed [TEMP_W-1:0] RST_BOILER_MIN = 8'sd30;
  localparam logic [7:0]               RST_RUN_MIN   = 8'd5;
  localparam logic [7:0]               RST_IDLE_MIN  = 8'd20;

  typedef enum logic [1:0] {
    MODE_AUTO  = 2'd0,
    MODE_PULSE = 2'd1,
    MODE_ON    = 2'd2,
    MODE_OFF   = 2'd3
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LOW_ON_TEMP     = 3'd0,
    REG_HIGH_OFF_TEMP   = 3'd1,
    REG_BOILER_MIN_TEMP = 3'd2,
    REG_RUN_MINUTES     = 3'd3,
    REG_IDLE_MINUTES    = 3'd4,
    REG_START_MODE      = 3'd5,
    REG_MEASURE_ALWAYS  = 3'd6,
    REG_AUTO_RECOVER    = 3'd7
  } cfg_reg_t;

endpackage

// ===== hdl/ptc_ifs.sv =====
interface ptc_in_if;
  logic              valid;
  logic              ready;
  logic signed [7:0] radiator_temp;
  logic signed [7:0] boiler_temp;

  modport source (output valid, output radiator_temp, output boiler_temp, input ready);
  modport sink   (input valid, input radiator_temp, input boiler_temp, output ready);
endinterface

interface ptc_out_if;
  logic       valid;
  logic       ready;
  logic       pump_on;
  logic       pulse_lamp;
  logic       auto_lamp;
  logic [1:0] mode_now;

  modport source (output valid, output pump_on, output pulse_lamp, output auto_lamp,
                  output mode_now, input ready);
  modport sink   (input valid, input pump_on, input pulse_lamp, input auto_lamp,
                  input mode_now, output ready);
endinterface

interface ptc_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] index;
  logic [7:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hdl/pump_thermostat_controller.sv =====
// Pump thermostat controller.
// in_ch  : one beat per tick, radiator and boiler readings (-90 = failed read).
// out_ch : one beat per tick, pump drive, pulse and auto lamps, working mode.
// cfg_ch : register writes (index 0..7), always ready, applied the same edge.
//          Write only while no tick is in flight.
// Two register stages (input register, result register) lie between a tick
// accepted on in_ch and its result on out_ch. Throughput: one tick per cycle
// while out_ch is ready; all tick logic sits between the input and result registers.
// A held result does not block input: the input register still takes one beat,
// then in_ch.ready drops until out_ch drains.
// Reset (rst_n low, synchronous): registers return to defaults, auto mode,
// pump off, fail count and elapsed time cleared, both channels empty.
module pump_thermostat_controller #(
  parameter int TICK_SECONDS = 8,
  parameter int FAIL_LIMIT   = 5
) (
  input  logic      clk,
  input  logic      rst_n,
  ptc_in_if.sink    in_ch,
  ptc_out_if.source out_ch,
  ptc_cfg_if.sink   cfg_ch
);
  import ptc_pkg::*;

  // configuration
  logic signed [TEMP_W-1:0] low_on_r, high_off_r, boiler_min_r;
  logic [7:0]               run_min_r, idle_min_r;
  logic                     measure_r, recover_r;

  // state
  mode_t                mode_r;
  logic                 pump_r;
  logic [FAIL_W-1:0]    fail_r;
  logic [ELAPSED_W-1:0] elapsed_r;

  // input register
  logic                     s_valid_r;
  logic signed [TEMP_W-1:0] s_rad_r, s_boil_r;

  // result register
  logic       o_valid_r;
  logic       o_pump_r, o_pulse_r, o_auto_r;
  logic [1:0] o_mode_r;

  logic advance;
  logic cfg_wr;

  assign advance      = s_valid_r && (!o_valid_r || out_ch.ready);
  assign in_ch.ready  = !s_valid_r || advance;
  assign cfg_ch.ready = 1'b1;
  assign cfg_wr       = cfg_ch.valid;

  assign out_ch.valid      = o_valid_r;
  assign out_ch.pump_on    = o_pump_r;
  assign out_ch.pulse_lamp = o_pulse_r;
  assign out_ch.auto_lamp  = o_auto_r;
  assign out_ch.mode_now   = o_mode_r;

  // tick logic
  mode_t                mode0, mode_nxt;
  logic                 pump_nxt, pl_nxt, al_nxt, allow, process, rad_fail, boil_fail;
  logic [FAIL_W-1:0]    fail_nxt;
  logic [ELAPSED_W-1:0] elapsed1, elapsed_nxt;
  logic [ELAPSED_W:0]   el_sum;
  logic [LIMIT_W-1:0]   limit;
  logic [7:0]           minutes;

  always_comb begin
    mode0 = mode_r;
    if (fail_r == '0 && recover_r) begin
      mode0 = MODE_AUTO;
    end
    process   = (mode0 == MODE_AUTO) || measure_r || recover_r;
    rad_fail  = (s_rad_r == FAIL_MARK);
    boil_fail = (s_boil_r == FAIL_MARK);

    mode_nxt = mode0;
    fail_nxt = fail_r;
    elapsed1 = elapsed_r;
    if (process) begin
      if (rad_fail) begin
        if (mode0 == MODE_AUTO) begin
          fail_nxt = (fail_r < FAIL_MAX) ? fail_r + 1'b1 : FAIL_MAX;
          if (fail_nxt >= FAIL_W'(FAIL_LIMIT)) begin
            mode_nxt = MODE_PULSE;
            elapsed1 = '0;
          end
        end
      end else begin
        fail_nxt = '0;
      end
    end

    pump_nxt    = pump_r;
    elapsed_nxt = elapsed1;
    allow       = 1'b1;
    pl_nxt      = 1'b0;
    al_nxt      = 1'b0;
    minutes     = pump_r ? run_min_r : idle_min_r;
    limit       = LIMIT_W'(minutes * SECONDS_PER_MINUTE);
    el_sum      = {1'b0, elapsed1} + (ELAPSED_W+1)'(TICK_SECONDS);

    case (mode_nxt)
      MODE_AUTO: begin
        al_nxt = 1'b1;
        if (!boil_fail) begin
          if (s_boil_r < boiler_min_r) begin
            allow    = 1'b0;
            pump_nxt = 1'b0;
          end
          if (s_rad_r >= s_boil_r) begin
            allow    = 1'b0;
            pump_nxt = 1'b0;
          end
        end
        if (!rad_fail) begin
          if (pump_nxt) begin
            if (s_rad_r >= high_off_r) pump_nxt = 1'b0;
          end else if (s_rad_r < low_on_r) begin
            pump_nxt = allow;
          end
        end
      end
      MODE_PULSE: begin
        pl_nxt      = 1'b1;
        elapsed_nxt = el_sum[ELAPSED_W] ? ELAPSED_MAX : el_sum[ELAPSED_W-1:0];
        if (elapsed_nxt > ELAPSED_W'(limit)) begin
          elapsed_nxt = '0;
          pump_nxt    = !pump_r;
        end
      end
      MODE_ON: begin
        pump_nxt = 1'b1;
        pl_nxt   = 1'b1;
        al_nxt   = 1'b1;
      end
      default: begin
        pump_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_on_r     <= RST_LOW_ON;
      high_off_r   <= RST_HIGH_OFF;
      boiler_min_r <= RST_BOILER_MIN;
      run_min_r    <= RST_RUN_MIN;
      idle_min_r   <= RST_IDLE_MIN;
      measure_r    <= 1'b0;
      recover_r    <= 1'b0;
      mode_r       <= MODE_AUTO;
      pump_r       <= 1'b0;
      fail_r       <= '0;
      elapsed_r    <= '0;
      s_valid_r    <= 1'b0;
      o_valid_r    <= 1'b0;
    end else begin
      if (in_ch.ready) begin
        s_valid_r <= in_ch.valid;
      end
      if (advance) begin
        o_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        o_valid_r <= 1'b0;
      end

      if (advance) begin
        mode_r    <= mode_nxt;
        pump_r    <= pump_nxt;
        fail_r    <= fail_nxt;
        elapsed_r <= elapsed_nxt;
      end

      if (cfg_wr) begin
        case (cfg_reg_t'(cfg_ch.index))
          REG_LOW_ON_TEMP:     low_on_r     <= $signed(cfg_ch.data);
          REG_HIGH_OFF_TEMP:   high_off_r   <= $signed(cfg_ch.data);
          REG_BOILER_MIN_TEMP: boiler_min_r <= $signed(cfg_ch.data);
          REG_RUN_MINUTES:     run_min_r    <= cfg_ch.data;
          REG_IDLE_MINUTES:    idle_min_r   <= cfg_ch.data;
          REG_START_MODE: begin
            mode_r    <= mode_t'(cfg_ch.data[1:0]);
            elapsed_r <= '0;
            if (mode_t'(cfg_ch.data[1:0]) == MODE_ON) begin
              pump_r <= 1'b1;
            end else if (mode_t'(cfg_ch.data[1:0]) == MODE_OFF) begin
              pump_r <= 1'b0;
            end
          end
          REG_MEASURE_ALWAYS:  measure_r <= cfg_ch.data[0];
          REG_AUTO_RECOVER:    recover_r <= cfg_ch.data[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s_rad_r  <= in_ch.radiator_temp;
      s_boil_r <= in_ch.boiler_temp;
    end
    if (advance) begin
      o_pump_r  <= pump_nxt;
      o_pulse_r <= pl_nxt;
      o_auto_r  <= al_nxt;
      o_mode_r  <= mode_nxt;
    end
  end

endmodule

// ===== sim/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ptc_pkg::*;

  localparam int FAIL_LIMIT_TICKS = 5;
  localparam int TICK_SECS        = 8;
  localparam int DRAIN_CYCLES     = 4;
  localparam int HOLD_CYCLES      = 300;
  localparam int WATCHDOG_LIMIT   = 3000;

  typedef struct packed {
    logic       pump_on;
    logic       pulse_lamp;
    logic       auto_lamp;
    logic [1:0] mode_now;
  } drive_t;

  logic clk = 1'b0;
  logic rst_n;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  ptc_in_if  in_ch();
  ptc_out_if out_ch();
  ptc_cfg_if cfg_ch();

  pump_thermostat_controller uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // predictor state
  logic signed [7:0] low_on_r, high_off_r, boiler_min_r;
  logic [7:0]        run_min_r, idle_min_r;
  logic              measure_r, recover_r;
  mode_t             mode_s;
  logic              pump_s;
  logic [2:0]        fail_cnt;
  logic [14:0]       elapsed_s;

  drive_t expected_drive_q[$];
  int     mismatch_count = 0;
  int     quiet_cycles   = 0;
  int     send_idle_pct  = 0;
  int     recv_stall_pct = 0;
  int     hold_left      = 0;

  function automatic void model_reset();
    low_on_r     = RST_LOW_ON;
    high_off_r   = RST_HIGH_OFF;
    boiler_min_r = RST_BOILER_MIN;
    run_min_r    = RST_RUN_MIN;
    idle_min_r   = RST_IDLE_MIN;
    measure_r    = 1'b0;
    recover_r    = 1'b0;
    mode_s       = MODE_AUTO;
    pump_s       = 1'b0;
    fail_cnt     = '0;
    elapsed_s    = '0;
  endfunction

  function automatic void apply_reg_write(logic [2:0] idx, logic [7:0] val);
    case (cfg_reg_t'(idx))
      REG_LOW_ON_TEMP:     low_on_r = val;
      REG_HIGH_OFF_TEMP:   high_off_r = val;
      REG_BOILER_MIN_TEMP: boiler_min_r = val;
      REG_RUN_MINUTES:     run_min_r = val;
      REG_IDLE_MINUTES:    idle_min_r = val;
      REG_START_MODE: begin
        mode_s = mode_t'(val[1:0]);
        elapsed_s = '0;
        if (mode_s == MODE_ON) pump_s = 1'b1;
        else if (mode_s == MODE_OFF) pump_s = 1'b0;
      end
      REG_MEASURE_ALWAYS:  measure_r = val[0];
      REG_AUTO_RECOVER:    recover_r = val[0];
      default: ;
    endcase
  endfunction

  function automatic drive_t thermostat_tick(logic signed [7:0] rad, logic signed [7:0] boil);
    drive_t d;
    logic   allow;
    int     secs;
    int     limit_secs;
    d = '0;
    if (fail_cnt == 0 && recover_r) mode_s = MODE_AUTO;
    if (mode_s == MODE_AUTO || measure_r || recover_r) begin
      if (rad == FAIL_MARK) begin
        if (mode_s == MODE_AUTO) begin
          if (fail_cnt != FAIL_MAX) fail_cnt = fail_cnt + 3'd1;
          if (fail_cnt >= FAIL_LIMIT_TICKS) begin
            mode_s = MODE_PULSE;
            elapsed_s = '0;
          end
        end
      end else begin
        fail_cnt = '0;
      end
    end
    case (mode_s)
      MODE_AUTO: begin
        allow = 1'b1;
        d.auto_lamp = 1'b1;
        // boiler lockout; a failed radiator still compares as its marker value
        if (boil != FAIL_MARK) begin
          if (boil < boiler_min_r || rad >= boil) begin
            allow = 1'b0;
            pump_s = 1'b0;
          end
        end
        if (rad != FAIL_MARK) begin
          if (pump_s) begin
            if (rad >= high_off_r) pump_s = 1'b0;
          end else if (rad < low_on_r) begin
            pump_s = allow;
          end
        end
      end
      MODE_PULSE: begin
        d.pulse_lamp = 1'b1;
        secs = int'(elapsed_s) + TICK_SECS;
        if (secs > int'(ELAPSED_MAX)) secs = int'(ELAPSED_MAX);
        limit_secs = (pump_s ? int'(run_min_r) : int'(idle_min_r)) * 60;
        if (secs > limit_secs) begin
          secs = 0;
          pump_s = ~pump_s;
        end
        elapsed_s = secs[14:0];
      end
      MODE_ON: begin
        pump_s = 1'b1;
        d.pulse_lamp = 1'b1;
        d.auto_lamp = 1'b1;
      end
      default: pump_s = 1'b0;
    endcase
    d.pump_on = pump_s;
    d.mode_now = mode_s;
    return d;
  endfunction

  function automatic void check_field(string field, logic [1:0] want, logic [1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      mismatch_count++;
    end
  endfunction

  // beat monitor, predictor update and watchdog
  always @(posedge clk) begin
    drive_t want;
    logic   progress;
    if (!rst_n) begin
      model_reset();
      quiet_cycles = 0;
    end else begin
      progress = 1'b0;
      if (out_ch.valid && out_ch.ready) begin
        progress = 1'b1;
        if (expected_drive_q.size() == 0) begin
          $error("result beat with no tick pending");
          mismatch_count++;
        end else begin
          want = expected_drive_q.pop_front();
          check_field("pump_on", 2'(want.pump_on), 2'(out_ch.pump_on));
          check_field("pulse_lamp", 2'(want.pulse_lamp), 2'(out_ch.pulse_lamp));
          check_field("auto_lamp", 2'(want.auto_lamp), 2'(out_ch.auto_lamp));
          check_field("mode_now", want.mode_now, out_ch.mode_now);
        end
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        progress = 1'b1;
        apply_reg_write(cfg_ch.index, cfg_ch.data);
      end
      if (in_ch.valid && in_ch.ready) begin
        progress = 1'b1;
        expected_drive_q.push_back(thermostat_tick(in_ch.radiator_temp, in_ch.boiler_temp));
      end
      quiet_cycles = progress ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $error("watchdog: no beat for %0d cycles", quiet_cycles);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // result receiver: random stalls plus long hold-off on request
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic send_tick(logic signed [7:0] rad, logic signed [7:0] boil);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.radiator_temp <= rad;
    in_ch.boiler_temp   <= boil;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (expected_drive_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [7:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic signed [7:0] pick_reading(int fail_pct);
    int r;
    r = $urandom_range(99);
    if (r < fail_pct) return FAIL_MARK;
    if (r < fail_pct + 15) return 8'($urandom_range(255));
    return 8'($urandom_range(75, 20));
  endfunction

  function automatic logic [7:0] pick_threshold();
    int r;
    r = $urandom_range(99);
    if (r < 5) return 8'h80;
    if (r < 10) return 8'h7F;
    if (r < 25) return 8'($urandom_range(255));
    return 8'($urandom_range(65, 25));
  endfunction

  function automatic logic [7:0] pick_minutes();
    return 8'(($urandom_range(9) == 0) ? $urandom_range(255) : $urandom_range(2));
  endfunction

  task automatic randomize_config();
    wait_idle();
    write_reg(REG_LOW_ON_TEMP, pick_threshold());
    write_reg(REG_HIGH_OFF_TEMP, pick_threshold());
    write_reg(REG_BOILER_MIN_TEMP, pick_threshold());
    write_reg(REG_RUN_MINUTES, pick_minutes());
    write_reg(REG_IDLE_MINUTES, pick_minutes());
    write_reg(REG_MEASURE_ALWAYS, 8'($urandom_range(1)));
    write_reg(REG_AUTO_RECOVER, 8'($urandom_range(1)));
    write_reg(REG_START_MODE,
              8'(($urandom_range(1) == 0) ? int'(MODE_AUTO) : int'($urandom_range(3))));
  endtask

  // mostly plain ticks, with runs of failed radiator reads to force pulse mode
  task automatic tick_burst(int count);
    int sent;
    int run_len;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(99) < 6) begin
        run_len = $urandom_range(7, 4);
        repeat (run_len) send_tick(FAIL_MARK, pick_reading(10));
        sent += run_len;
      end else begin
        send_tick(pick_reading(10), pick_reading(5));
        sent++;
      end
    end
  endtask

  task automatic test_auto_hysteresis();
    send_tick(8'sd40, 8'sd60);
    send_tick(8'sd50, 8'sd60);
    send_tick(8'sd55, 8'sd60);
    send_tick(8'sd44, 8'sd20);
    send_tick(8'sd44, FAIL_MARK);
    send_tick(8'sd70, 8'sd65);
    send_tick(8'sd127, -8'sd128);
    send_tick(-8'sd128, 8'sd127);
    send_tick(FAIL_MARK, -8'sd100);
    repeat (4) send_tick(FAIL_MARK, 8'sd60);
    send_tick(8'sd40, 8'sd60);
  endtask

  task automatic test_modes_and_registers();
    wait_idle();
    // zero pulse times toggle the pump on every tick
    write_reg(REG_RUN_MINUTES, 8'd0);
    write_reg(REG_IDLE_MINUTES, 8'd0);
    repeat (2) send_tick(8'sd40, 8'sd60);
    // fail count climbs to saturation across returns to auto
    repeat (3) begin
      wait_idle();
      write_reg(REG_START_MODE, 8'(MODE_AUTO));
      send_tick(FAIL_MARK, 8'sd60);
    end
    wait_idle();
    write_reg(REG_AUTO_RECOVER, 8'd1);
    send_tick(FAIL_MARK, 8'sd60);
    send_tick(8'sd40, 8'sd60);
    send_tick(8'sd40, 8'sd60);
    wait_idle();
    write_reg(REG_AUTO_RECOVER, 8'd0);
    write_reg(REG_MEASURE_ALWAYS, 8'd1);
    write_reg(REG_START_MODE, 8'(MODE_OFF));
    send_tick(FAIL_MARK, 8'sd60);
    send_tick(8'sd40, 8'sd60);
    wait_idle();
    write_reg(REG_START_MODE, 8'(MODE_ON));
    send_tick(8'sd40, 8'sd60);
    wait_idle();
    write_reg(REG_LOW_ON_TEMP, 8'h7F);
    write_reg(REG_HIGH_OFF_TEMP, 8'h80);
    write_reg(REG_BOILER_MIN_TEMP, 8'h80);
    write_reg(REG_START_MODE, 8'(MODE_AUTO));
    send_tick(8'sd100, 8'sd120);
    send_tick(8'sd100, 8'sd120);
    wait_idle();
    write_reg(REG_BOILER_MIN_TEMP, 8'h7F);
    write_reg(REG_RUN_MINUTES, 8'hFF);
    write_reg(REG_IDLE_MINUTES, 8'hFF);
    send_tick(8'sd0, 8'sd126);
    wait_idle();
    write_reg(REG_START_MODE, 8'(MODE_PULSE));
    send_tick(8'sd0, 8'sd126);
  endtask

  task automatic test_random_traffic();
    int idle_pct[4]  = '{0, 60, 0, 27};
    int stall_pct[4] = '{0, 0, 60, 27};
    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = idle_pct[p];
      recv_stall_pct = stall_pct[p];
      repeat (4) begin
        randomize_config();
        tick_burst(60);
      end
    end
  endtask

  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    randomize_config();
    hold_left = HOLD_CYCLES;
    tick_burst(40);
    wait_idle();
  endtask

  initial begin
    rst_n               = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.radiator_temp = '0;
    in_ch.boiler_temp   = '0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.index        = '0;
    cfg_ch.data         = '0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    test_auto_hysteresis();
    test_modes_and_registers();
    test_random_traffic();
    test_backpressure();

    wait_idle();
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== pump_thermostat_controller.f =====
hdl/ptc_pkg.sv
hdl/ptc_ifs.sv
hdl/pump_thermostat_controller.sv
sim/tb_top.sv
